### rtl/kqs_pkg.sv
package kqs_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int REC_W           = 48;

  // One stored record, last field in the lowest bits (same layout as tdata)
  typedef struct packed {
    logic [31:0] score;
    logic [7:0]  y;
    logic [7:0]  x;
  } rec_t;

  typedef enum logic [4:0] {
    S_LOAD, S_POP, S_POPW,
    S_MA, S_MB, S_MC, S_M1, S_M2, S_M3,
    S_MW1, S_MW2, S_MW3,
    S_CHI, S_CHJ, S_SW1, S_SW2,
    S_PU1, S_PU2,
    S_ERD, S_ELD, S_EWT
  } state_t;

  // Signed score comparison: a greater than b
  function automatic logic score_gt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

### rtl/kqs_ram.sv
module kqs_ram #(
  parameter int W = 48,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // forward a same-cycle write to the same entry
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/keyed_record_quicksort.sv
// keyed_record_quicksort
// Input channel (in_*): one record per transaction, x, y and signed score in
// in_tdata; in_tlast marks the final record of a set and starts the sort.
// Records beyond MAX_RECORDS are dropped and the set is flagged.
// While loading, one transaction is taken per cycle. After the last one,
// in_tready stays low through the sort and the whole emit burst.
// Sort: quicksort with Hoare partition and median-of-three pivot, pending
// ranges held on a stack memory. Records live in a one-read one-write
// synchronous RAM, so a partition step runs as a sequence of states: read
// low, mid and high, order the three, write them back (low and high only for
// a two-record range), scan from both ends with a swap (two writes) per
// out-of-place pair, and finally push the non-trivial halves on the stack.
// Output channel (out_*): records in ascending score order, out_tlast on the
// final one, out_tuser carries the dropped flag. Each record is read from the
// RAM, registered and then offered until out_tready; a stalled record holds.
// Reset (rst_n low, synchronous) empties the loader and drops any burst.
module keyed_record_quicksort
  import kqs_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coord_x[7:0], coord_y[15:8], score[47:16]
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_x[7:0], out_y[15:8], out_score[47:16]
  output logic        out_tlast,  // out_last
  output logic        out_tuser   // dropped
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int SW = 2 * IW;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  rec_t          a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [31:0]   pivot_r, pivot_nxt;
  logic          alias_r, alias_nxt;
  rec_t          out_rec_r, out_rec_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;

  // record RAM port
  logic          rw_we;
  logic [IW-1:0] rw_waddr, rd_addr;
  rec_t          rw_wdata, rq;
  // range stack port
  logic          sw_we;
  logic [IW-1:0] sw_addr, st_raddr;
  logic [SW-1:0] sw_data, sq;

  logic [CW-1:0] n_new;
  logic [IW-1:0] pop_lo, pop_hi;

  kqs_ram #(.W(REC_W), .D(MAX_RECORDS)) u_rec_ram (
    .clk(clk), .we(rw_we), .waddr(rw_waddr), .wdata(rw_wdata),
    .raddr(rd_addr), .rdata(rq)
  );

  kqs_ram #(.W(SW), .D(MAX_RECORDS)) u_stack_ram (
    .clk(clk), .we(sw_we), .waddr(sw_addr), .wdata(sw_data),
    .raddr(st_raddr), .rdata(sq)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = ovf_r;

  assign pop_lo = sq[SW-1:IW];
  assign pop_hi = sq[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    pivot_r   <= pivot_nxt;
    alias_r   <= alias_nxt;
    out_rec_r <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    pivot_nxt     = pivot_r;
    alias_nxt     = alias_r;
    out_rec_nxt   = out_rec_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    rw_we         = 1'b0;
    rw_waddr      = i_r;
    rw_wdata      = a_r;
    rd_addr       = i_r;
    sw_we         = 1'b0;
    sw_addr       = sp_r[IW-1:0];
    sw_data       = {lo_r, j_r};
    st_raddr      = sp_r[IW-1:0];
    n_new         = cnt_r;

    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CW'(MAX_RECORDS)) begin
            rw_we    = 1'b1;
            rw_waddr = cnt_r[IW-1:0];
            rw_wdata = in_tdata;
            n_new    = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (in_tlast) begin
            k_nxt = '0;
            if (n_new >= CW'(2)) begin
              // seed the stack with the whole set
              sw_we     = 1'b1;
              sw_addr   = '0;
              sw_data   = {{IW{1'b0}}, IW'(n_new - CW'(1))};
              sp_nxt    = CW'(1);
              state_nxt = S_POP;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          st_raddr  = IW'(sp_r - CW'(1));
          sp_nxt    = sp_r - CW'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        if (pop_lo >= pop_hi) begin
          state_nxt = S_POP;
        end else begin
          lo_nxt    = pop_lo;
          hi_nxt    = pop_hi;
          mid_nxt   = pop_lo + ((pop_hi - pop_lo) >> 1);
          rd_addr   = pop_lo;
          state_nxt = S_MA;
        end
      end
      S_MA: begin
        a_nxt     = rq;
        rd_addr   = mid_r;
        state_nxt = S_MB;
      end
      S_MB: begin
        b_nxt     = rq;
        rd_addr   = hi_r;
        state_nxt = S_MC;
      end
      S_MC: begin
        c_nxt     = rq;
        alias_nxt = (lo_r == mid_r);
        state_nxt = S_M1;
      end
      S_M1: begin
        if (score_gt(a_r.score, b_r.score)) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        state_nxt = S_M2;
      end
      S_M2: begin
        if (score_gt(a_r.score, c_r.score)) begin
          a_nxt = c_r;
          c_nxt = a_r;
        end
        state_nxt = S_M3;
      end
      S_M3: begin
        // with low and mid the same entry, the mid/high step is void
        if (!alias_r && score_gt(b_r.score, c_r.score)) begin
          b_nxt = c_r;
          c_nxt = b_r;
        end
        state_nxt = S_MW1;
      end
      S_MW1: begin
        rw_we     = 1'b1;
        rw_waddr  = lo_r;
        rw_wdata  = alias_r ? a_r : b_r;
        pivot_nxt = alias_r ? a_r.score : b_r.score;
        state_nxt = S_MW2;
      end
      S_MW2: begin
        rw_we = 1'b1;
        if (alias_r) begin
          rw_waddr  = hi_r;
          rw_wdata  = c_r;
          i_nxt     = lo_r;
          j_nxt     = hi_r;
          rd_addr   = lo_r;
          state_nxt = S_CHI;
        end else begin
          rw_waddr  = mid_r;
          rw_wdata  = a_r;
          state_nxt = S_MW3;
        end
      end
      S_MW3: begin
        rw_we     = 1'b1;
        rw_waddr  = hi_r;
        rw_wdata  = c_r;
        i_nxt     = lo_r;
        j_nxt     = hi_r;
        rd_addr   = lo_r;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        if (i_r < hi_r && score_gt(pivot_r, rq.score)) begin
          i_nxt   = i_r + IW'(1);
          rd_addr = i_r + IW'(1);
        end else begin
          a_nxt     = rq;
          rd_addr   = j_r;
          state_nxt = S_CHJ;
        end
      end
      S_CHJ: begin
        if (j_r > lo_r && score_gt(rq.score, pivot_r)) begin
          j_nxt   = j_r - IW'(1);
          rd_addr = j_r - IW'(1);
        end else begin
          b_nxt     = rq;
          state_nxt = (i_r >= j_r) ? S_PU1 : S_SW1;
        end
      end
      S_SW1: begin
        rw_we     = 1'b1;
        rw_waddr  = i_r;
        rw_wdata  = b_r;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        rw_we     = 1'b1;
        rw_waddr  = j_r;
        rw_wdata  = a_r;
        i_nxt     = i_r + IW'(1);
        j_nxt     = j_r - IW'(1);
        rd_addr   = i_r + IW'(1);
        state_nxt = S_CHI;
      end
      S_PU1: begin
        if (j_r > lo_r) begin
          sw_we   = 1'b1;
          sw_data = {lo_r, j_r};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_PU2;
      end
      S_PU2: begin
        if ((IW+1)'(hi_r) > (IW+1)'(j_r) + (IW+1)'(1)) begin
          sw_we   = 1'b1;
          sw_data = {j_r + IW'(1), hi_r};
          sp_nxt  = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_ERD: begin
        rd_addr   = k_r;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        out_rec_nxt   = rq;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (CW'(k_r) + CW'(1) == cnt_r);
        state_nxt     = S_EWT;
      end
      S_EWT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### rtl/kqs_chk.sv
module kqs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is offered");

  // the last input transaction closes the loader
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("loader still open after last record");

  // the last result transaction reopens the loader
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("loader not reopened after burst");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind keyed_record_quicksort kqs_chk u_kqs_chk (.*);
